/* design/dda_line_rasterizer_defines.svh */
// Assertion macros shared by the line rasterizer checks.
`ifndef DDA_LINE_RASTERIZER_DEFINES_SVH
`define DDA_LINE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DDA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/dda_pkg.sv */
// Shared constants, codes and control structs of the line rasterizer.
package dda_pkg;

    // Fixed-point format of the position
    localparam int FRAC_BITS  = 16;
    localparam int COORD_BITS = 16;

    // Derived widths
    localparam int DELTA_BITS = COORD_BITS + 1;              // endpoint difference
    localparam int POS_BITS   = COORD_BITS + FRAC_BITS + 1;  // signed position
    localparam int QUO_BITS   = FRAC_BITS + 1;               // |inc| <= 1.0
    localparam int INC_BITS   = FRAC_BITS + 2;               // signed increment
    localparam int RND_BITS   = COORD_BITS + 2;              // rounded coordinate
    localparam int REM_BITS   = DELTA_BITS + 1;              // divider remainder
    localparam int CNT_BITS   = $clog2(QUO_BITS);

    // Fixed field widths
    localparam int DIM_BITS     = 13;
    localparam int ADDR_BITS    = 24;
    localparam int COLOR_BITS   = 32;
    localparam int CFG_IDX_BITS = 2;

    // Register reset values
    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(800);
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(600);

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = CFG_IDX_BITS'(1);

    // Command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // Divider request and response
    typedef struct packed {
        logic                  start;
        logic [DELTA_BITS-1:0] dividend;
        logic [DELTA_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [QUO_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

/* design/dda_cmd_if.sv */
// Command channel: line endpoints, color and command code.
interface dda_cmd_if;
    logic                              valid;
    logic                              ready;
    logic                              cmd;
    logic signed [dda_pkg::COORD_BITS-1:0] start_x;
    logic signed [dda_pkg::COORD_BITS-1:0] start_y;
    logic signed [dda_pkg::COORD_BITS-1:0] end_x;
    logic signed [dda_pkg::COORD_BITS-1:0] end_y;
    logic [dda_pkg::COLOR_BITS-1:0]    line_color;

    modport source (
        output valid, cmd, start_x, start_y, end_x, end_y, line_color,
        input  ready
    );

    modport sink (
        input  valid, cmd, start_x, start_y, end_x, end_y, line_color,
        output ready
    );
endinterface

/* design/dda_pix_if.sv */
// Pixel channel: one rasterized pixel per beat.
interface dda_pix_if;
    logic                              valid;
    logic                              ready;
    logic signed [dda_pkg::COORD_BITS-1:0] pixel_x;
    logic signed [dda_pkg::COORD_BITS-1:0] pixel_y;
    logic [dda_pkg::ADDR_BITS-1:0]     pixel_address;
    logic [dda_pkg::COLOR_BITS-1:0]    pixel_color;
    logic                              visible;
    logic                              last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, pixel_address, pixel_color, visible, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, pixel_address, pixel_color, visible, last_pixel,
        output ready
    );
endinterface

/* design/dda_div.sv */
// Restoring divider, one quotient bit per cycle, for |delta| * 2^FRAC / steps.
module dda_div (
    input  logic              clk,
    input  logic              rst_n,
    input  dda_pkg::div_req_t req,
    output dda_pkg::div_rsp_t rsp
);

    typedef enum logic {
        D_IDLE,
        D_RUN
    } div_state_t;

    div_state_t                       state_reg;
    logic [dda_pkg::REM_BITS-1:0]     rem_reg;
    logic [dda_pkg::DELTA_BITS-1:0]   den_reg;
    logic [dda_pkg::QUO_BITS-1:0]     quo_reg;
    logic [dda_pkg::CNT_BITS-1:0]     cnt_reg;
    logic                             done_reg;

    logic [dda_pkg::REM_BITS-1:0]     den_ext;
    logic                             fits;
    logic [dda_pkg::REM_BITS-1:0]     rem_kept;
    logic                             last_iter;

    // One trial subtraction per cycle; the dividend ratio never exceeds one,
    // so the leading bit comes from the unshifted magnitude
    assign den_ext   = {1'b0, den_reg};
    assign fits      = rem_reg >= den_ext;
    assign rem_kept  = fits ? (rem_reg - den_ext) : rem_reg;
    assign last_iter = cnt_reg == dda_pkg::CNT_BITS'(dda_pkg::QUO_BITS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            rem_reg   <= '0;
            den_reg   <= '0;
            quo_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            // Done pulses for one cycle after the final quotient bit
            done_reg <= (state_reg == D_RUN) && last_iter;
            case (state_reg)
                D_IDLE:
                begin
                    if (req.start)
                    begin
                        rem_reg   <= {1'b0, req.dividend};
                        den_reg   <= req.divisor;
                        quo_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    quo_reg <= {quo_reg[dda_pkg::QUO_BITS-2:0], fits};
                    rem_reg <= {rem_kept[dda_pkg::REM_BITS-2:0], 1'b0};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (last_iter)
                    begin
                        state_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign rsp.busy     = state_reg == D_RUN;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

/* design/dda_line_rasterizer.sv */
// Line rasterizer top level: command sequencer, pixel datapath, output register.
//
//   channel    dir   beat contents
//   cmd_ch     in    cmd, start_x, start_y, end_x, end_y, line_color
//   pixel_ch   out   pixel_x, pixel_y, pixel_address, pixel_color, visible, last_pixel
//   cfg_*      in    cfg_index 0 width, 1 height; cfg_data 13 bits, one write per cycle
//
// A start beat takes absolute values and the step count, then the shared
// divider runs one quotient bit per cycle, first for x, then for y.
// A step beat passes through accept, round and advance, multiply and address add.
// A finished pixel waits in the output register while the next beat is taken;
// the sequencer stalls in its address stage only if that register is still full.
// Reset is asynchronous and leaves the block idle with width 800, height 600.
`include "dda_line_rasterizer_defines.svh"

module dda_line_rasterizer (
    input  logic                              clk,
    input  logic                              rst_n,
    dda_cmd_if.sink                           cmd_ch,
    dda_pix_if.source                         pixel_ch,
    input  logic                              cfg_we,
    input  logic [dda_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [dda_pkg::DIM_BITS-1:0]      cfg_data
);

    localparam int POS_BITS = dda_pkg::POS_BITS;
    localparam int INC_BITS = dda_pkg::INC_BITS;
    localparam int RND_BITS = dda_pkg::RND_BITS;
    localparam int DLT_BITS = dda_pkg::DELTA_BITS;
    localparam int DIM_BITS = dda_pkg::DIM_BITS;

    localparam logic [POS_BITS:0] HALF_UP = (POS_BITS+1)'(64'd1 << (dda_pkg::FRAC_BITS - 1));
    localparam logic [POS_BITS:0] HALF_DN = HALF_UP - 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ABS,
        S_MAX,
        S_DIVX,
        S_DIVY,
        S_RND,
        S_MUL,
        S_OUT
    } seq_state_t;

    seq_state_t state_reg, state_next;

    // Configuration
    logic [DIM_BITS-1:0] width_reg;
    logic [DIM_BITS-1:0] height_reg;

    // Line state
    logic [DLT_BITS-1:0]             dx_reg, dy_reg;
    logic [DLT_BITS-1:0]             ax_reg, ay_reg;
    logic [POS_BITS-1:0]             pos_x_reg, pos_y_reg;
    logic [INC_BITS-1:0]             inc_x_reg, inc_y_reg;
    logic [DLT_BITS-1:0]             steps_left_reg;
    logic [dda_pkg::COLOR_BITS-1:0]  color_reg;
    logic                            busy_reg;

    // Pixel datapath
    logic [RND_BITS-1:0]             px_reg, py_reg;
    logic                            last_reg;
    logic                            vis_reg;
    logic [dda_pkg::ADDR_BITS-1:0]   prod_reg;

    // Output register
    logic                                   out_valid_reg;
    logic [dda_pkg::COORD_BITS-1:0]         out_x_reg, out_y_reg;
    logic [dda_pkg::ADDR_BITS-1:0]          out_addr_reg;
    logic [dda_pkg::COLOR_BITS-1:0]         out_color_reg;
    logic                                   out_vis_reg;
    logic                                   out_last_reg;

    dda_pkg::div_req_t div_req;
    dda_pkg::div_rsp_t div_rsp;

    logic                       cmd_accept;
    logic [DLT_BITS-1:0]        dx_c, dy_c;
    logic [DLT_BITS-1:0]        max_c;
    logic                       inc_neg;
    logic [INC_BITS-1:0]        quo_ext;
    logic [INC_BITS-1:0]        inc_c;
    logic [POS_BITS:0]          rnd_x_sum, rnd_y_sum;
    logic                       vis_c;
    logic [2*DIM_BITS-1:0]      prod_c;
    logic [dda_pkg::ADDR_BITS-1:0] addr_c;
    logic                       out_load;

    // Check terms
    logic                       start_accept;
    logic                       div_phase;
    logic                       clipped_out;
    logic                       last_step;

    assign cmd_ch.ready = state_reg == S_IDLE;
    assign cmd_accept   = cmd_ch.valid && cmd_ch.ready;

    // Endpoint differences
    assign dx_c = {cmd_ch.end_x[dda_pkg::COORD_BITS-1], cmd_ch.end_x}
                - {cmd_ch.start_x[dda_pkg::COORD_BITS-1], cmd_ch.start_x};
    assign dy_c = {cmd_ch.end_y[dda_pkg::COORD_BITS-1], cmd_ch.end_y}
                - {cmd_ch.start_y[dda_pkg::COORD_BITS-1], cmd_ch.start_y};

    // Step count is the larger magnitude
    assign max_c = (ax_reg >= ay_reg) ? ax_reg : ay_reg;

    // Divider requests: x once the count is known, y as soon as x finishes
    assign div_req.start    = (state_reg == S_MAX) || (state_reg == S_DIVX && div_rsp.done);
    assign div_req.dividend = (state_reg == S_MAX) ? ax_reg : ay_reg;
    assign div_req.divisor  = (state_reg == S_MAX) ? max_c : steps_left_reg;

    dda_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Signed increment; a zero-length line gets none
    assign inc_neg = (state_reg == S_DIVX) ? dx_reg[DLT_BITS-1] : dy_reg[DLT_BITS-1];
    assign quo_ext = {1'b0, div_rsp.quotient};
    assign inc_c   = (steps_left_reg == '0) ? '0 : (inc_neg ? (~quo_ext + 1'b1) : quo_ext);

    // Round half away from zero: negative values add half minus one, then floor
    assign rnd_x_sum = {pos_x_reg[POS_BITS-1], pos_x_reg}
                     + (pos_x_reg[POS_BITS-1] ? HALF_DN : HALF_UP);
    assign rnd_y_sum = {pos_y_reg[POS_BITS-1], pos_y_reg}
                     + (pos_y_reg[POS_BITS-1] ? HALF_DN : HALF_UP);

    // Clip test and row offset
    assign vis_c  = !px_reg[RND_BITS-1] && (px_reg < RND_BITS'(width_reg)) &&
                    !py_reg[RND_BITS-1] && (py_reg < RND_BITS'(height_reg));
    assign prod_c = py_reg[DIM_BITS-1:0] * width_reg;
    assign addr_c = vis_reg ? (prod_reg + dda_pkg::ADDR_BITS'(px_reg[DIM_BITS-1:0])) : '0;

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || pixel_ch.ready);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    if (cmd_ch.cmd == dda_pkg::CMD_START)
                        state_next = S_ABS;
                    else if (busy_reg)
                        state_next = S_RND;
                end
            end
            S_ABS:  state_next = S_MAX;
            S_MAX:  state_next = S_DIVX;
            S_DIVX: if (div_rsp.done) state_next = S_DIVY;
            S_DIVY: if (div_rsp.done) state_next = S_IDLE;
            S_RND:  state_next = S_MUL;
            S_MUL:  state_next = S_OUT;
            S_OUT:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= dda_pkg::WIDTH_RESET;
            height_reg <= dda_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dda_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                dda_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            busy_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            inc_x_reg      <= '0;
            inc_y_reg      <= '0;
            steps_left_reg <= '0;
            color_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (pixel_ch.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_accept && cmd_ch.cmd == dda_pkg::CMD_START)
                    begin
                        dx_reg    <= dx_c;
                        dy_reg    <= dy_c;
                        pos_x_reg <= {cmd_ch.start_x[dda_pkg::COORD_BITS-1], cmd_ch.start_x,
                                      {dda_pkg::FRAC_BITS{1'b0}}};
                        pos_y_reg <= {cmd_ch.start_y[dda_pkg::COORD_BITS-1], cmd_ch.start_y,
                                      {dda_pkg::FRAC_BITS{1'b0}}};
                        color_reg <= cmd_ch.line_color;
                        busy_reg  <= 1'b1;
                    end
                end
                S_ABS:
                begin
                    ax_reg <= dx_reg[DLT_BITS-1] ? (~dx_reg + 1'b1) : dx_reg;
                    ay_reg <= dy_reg[DLT_BITS-1] ? (~dy_reg + 1'b1) : dy_reg;
                end
                S_MAX:
                begin
                    steps_left_reg <= max_c;
                end
                S_DIVX:
                begin
                    if (div_rsp.done)
                        inc_x_reg <= inc_c;
                end
                S_DIVY:
                begin
                    if (div_rsp.done)
                        inc_y_reg <= inc_c;
                end
                S_RND:
                begin
                    px_reg   <= rnd_x_sum[dda_pkg::FRAC_BITS +: RND_BITS];
                    py_reg   <= rnd_y_sum[dda_pkg::FRAC_BITS +: RND_BITS];
                    last_reg <= steps_left_reg == '0;
                    if (steps_left_reg == '0)
                    begin
                        busy_reg <= 1'b0;
                    end
                    else
                    begin
                        steps_left_reg <= steps_left_reg - 1'b1;
                        pos_x_reg <= pos_x_reg
                                   + {{(POS_BITS-INC_BITS){inc_x_reg[INC_BITS-1]}}, inc_x_reg};
                        pos_y_reg <= pos_y_reg
                                   + {{(POS_BITS-INC_BITS){inc_y_reg[INC_BITS-1]}}, inc_y_reg};
                    end
                end
                S_MUL:
                begin
                    vis_reg  <= vis_c;
                    prod_reg <= prod_c[dda_pkg::ADDR_BITS-1:0];
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        out_x_reg     <= px_reg[dda_pkg::COORD_BITS-1:0];
                        out_y_reg     <= py_reg[dda_pkg::COORD_BITS-1:0];
                        out_addr_reg  <= addr_c;
                        out_color_reg <= color_reg;
                        out_vis_reg   <= vis_reg;
                        out_last_reg  <= last_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign pixel_ch.valid         = out_valid_reg;
    assign pixel_ch.pixel_x       = out_x_reg;
    assign pixel_ch.pixel_y       = out_y_reg;
    assign pixel_ch.pixel_address = out_addr_reg;
    assign pixel_ch.pixel_color   = out_color_reg;
    assign pixel_ch.visible       = out_vis_reg;
    assign pixel_ch.last_pixel    = out_last_reg;

    // Checks
    assign start_accept = cmd_accept && (cmd_ch.cmd == dda_pkg::CMD_START);
    assign div_phase    = (state_reg == S_DIVX) || (state_reg == S_DIVY);
    assign clipped_out  = out_valid_reg && !out_vis_reg;
    assign last_step    = (state_reg == S_RND) && (steps_left_reg == '0);

    `DDA_ASSERT_NEXT(a_start_seq, start_accept, state_reg == S_ABS, "start beat skipped setup")
    `DDA_ASSERT_NOW(a_div_owner, div_rsp.done, div_phase, "divider done outside a divide")
    `DDA_ASSERT_NOW(a_clip_addr, clipped_out, out_addr_reg == '0, "clipped pixel has an address")
    `DDA_ASSERT_NEXT(a_last_idle, last_step, !busy_reg, "line busy after last pixel")
    `DDA_ASSERT_NOW(a_div_free, state_reg == S_IDLE, !div_rsp.busy, "divider busy while idle")

endmodule
